// ===== rtl/lldq_pkg.sv =====
package lldq_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int LEVELS      = $clog2(CAPACITY);
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

    typedef struct packed {
        logic                   valid;
        logic [VALUE_WIDTH-1:0] value;
    } t_cell_data;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [VALUE_WIDTH-1:0] value;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [COUNT_W-1:0]     count;
        logic                   is_empty;
        logic [VALUE_WIDTH-1:0] front_value;
        logic [VALUE_WIDTH-1:0] back_value;
    } t_out;

    // Log-depth prefix OR: bit i is set when any bit at or below i is set.
    function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
        logic [CAPACITY-1:0] r;
        logic [CAPACITY-1:0] prev;
        r = v;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            prev = r;
            for (int i = 0; i < CAPACITY; i++) begin
                if (i >= (1 << lvl)) begin
                    r[i] = prev[i] | prev[i - (1 << lvl)];
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/lldq_cell.sv =====
module lldq_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lldq_pkg::t_cell_op                  i_op,
    input  logic [lldq_pkg::VALUE_WIDTH-1:0]    i_load_value,
    input  lldq_pkg::t_cell_data                i_left,
    input  lldq_pkg::t_cell_data                i_right,
    input  logic                                i_cmp_en,
    input  logic [lldq_pkg::VALUE_WIDTH-1:0]    i_key,
    output lldq_pkg::t_cell_data                o_data,
    output logic                                o_match
);

    logic                             r_valid;
    logic [lldq_pkg::VALUE_WIDTH-1:0] r_value;
    logic                             r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_op)
                lldq_pkg::CELL_HOLD:       r_valid <= r_valid;
                lldq_pkg::CELL_LOAD:       r_valid <= 1'b1;
                lldq_pkg::CELL_FROM_LEFT:  r_valid <= i_left.valid;
                lldq_pkg::CELL_FROM_RIGHT: r_valid <= i_right.valid;
                default:                   r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            lldq_pkg::CELL_HOLD:       r_value <= r_value;
            lldq_pkg::CELL_LOAD:       r_value <= i_load_value;
            lldq_pkg::CELL_FROM_LEFT:  r_value <= i_left.value;
            lldq_pkg::CELL_FROM_RIGHT: r_value <= i_right.value;
            default:                   r_value <= r_value;
        endcase
    end

    // The compare is taken when the word arrives, so the search runs in every cell at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmp_en) begin
            r_match <= r_valid && (r_value == i_key);
        end
    end

    assign o_data.valid = r_valid;
    assign o_data.value = r_value;
    assign o_match      = r_match;

endmodule

// ===== rtl/linked_list_deque_engine.sv =====
// Ordered deque of up to 64 values held as a row of cells, position 0 being the
// front. A word is taken when start is high and busy is low; busy is then high
// for one cycle while the row shifts or loads, and in the following cycle o_done
// strobes the result for exactly one cycle, which the receiver must take as it
// cannot stall it. A new word may be started in that same result cycle, so the
// block overlaps each result with the next word for every command, removal included:
// the value compare happens in all cells in parallel as the word is accepted.
module linked_list_deque_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lldq_pkg::t_in  i_cmd,
    output logic           o_done,
    output lldq_pkg::t_out o_result
);

    localparam int N = lldq_pkg::CAPACITY;

    lldq_pkg::t_state r_state;
    lldq_pkg::t_state n_state;

    logic [lldq_pkg::CMD_W-1:0]       r_command;
    logic [lldq_pkg::VALUE_WIDTH-1:0] r_value;
    logic [lldq_pkg::COUNT_W-1:0]     r_count;
    logic [lldq_pkg::COUNT_W-1:0]     n_count;
    logic [lldq_pkg::STATUS_W-1:0]    r_status;
    logic [lldq_pkg::STATUS_W-1:0]    n_status;

    lldq_pkg::t_cell_data cell_data [N];
    lldq_pkg::t_cell_op   cell_op   [N];
    logic [N-1:0]         valid_vec;
    logic [N-1:0]         match_vec;
    logic [N-1:0]         last_vec;
    logic [N-1:0]         free_vec;
    logic [N-1:0]         shift_mask;
    logic [N-1:0]         load_vec;
    logic                 shift_left_all;
    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic [lldq_pkg::VALUE_WIDTH-1:0] back_value;

    assign accept = start && !busy;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            lldq_pkg::t_cell_data left_in;
            lldq_pkg::t_cell_data right_in;

            if (g == 0) begin : g_first
                assign left_in = '0;
            end else begin : g_mid_l
                assign left_in = cell_data[g-1];
            end
            if (g == N - 1) begin : g_last
                assign right_in = '0;
            end else begin : g_mid_r
                assign right_in = cell_data[g+1];
            end

            lldq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_op         (cell_op[g]),
                .i_load_value (r_value),
                .i_left       (left_in),
                .i_right      (right_in),
                .i_cmp_en     (accept),
                .i_key        (i_cmd.value),
                .o_data       (cell_data[g]),
                .o_match      (match_vec[g])
            );

            assign valid_vec[g] = cell_data[g].valid;
        end
    endgenerate

    // The back of the list is the last valid cell; a free slot is the first invalid one.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (i == N - 1) begin
                last_vec[i] = valid_vec[i];
            end else begin
                last_vec[i] = valid_vec[i] && !valid_vec[i+1];
            end
            if (i == 0) begin
                free_vec[i] = !valid_vec[i];
            end else begin
                free_vec[i] = !valid_vec[i] && valid_vec[i-1];
            end
        end
    end

    assign is_full  = (r_count == lldq_pkg::COUNT_W'(N));
    assign is_empty = (r_count == '0);

    // A removal at position k makes every cell from k onwards take its right neighbour.
    always_comb begin
        shift_mask     = '0;
        load_vec       = '0;
        shift_left_all = 1'b0;
        n_count        = r_count;
        n_status       = lldq_pkg::STATUS_DONE;
        if (r_state == lldq_pkg::ST_EXEC) begin
            unique case (r_command)
                lldq_pkg::CMD_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = lldq_pkg::STATUS_FULL;
                    end else begin
                        shift_left_all = 1'b1;
                        n_count        = r_count + lldq_pkg::COUNT_W'(1);
                    end
                end
                lldq_pkg::CMD_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = lldq_pkg::STATUS_FULL;
                    end else begin
                        load_vec = free_vec;
                        n_count  = r_count + lldq_pkg::COUNT_W'(1);
                    end
                end
                lldq_pkg::CMD_POP_FRONT: begin
                    if (is_empty) begin
                        n_status = lldq_pkg::STATUS_MISS;
                    end else begin
                        shift_mask = '1;
                        n_count    = r_count - lldq_pkg::COUNT_W'(1);
                    end
                end
                lldq_pkg::CMD_POP_BACK: begin
                    if (is_empty) begin
                        n_status = lldq_pkg::STATUS_MISS;
                    end else begin
                        shift_mask = last_vec;
                        n_count    = r_count - lldq_pkg::COUNT_W'(1);
                    end
                end
                lldq_pkg::CMD_REMOVE: begin
                    if (is_empty || (match_vec == '0)) begin
                        n_status = lldq_pkg::STATUS_MISS;
                    end else begin
                        // The head wins, then the tail, then the first match from the front.
                        if (!match_vec[0] && ((match_vec & last_vec) != '0)) begin
                            shift_mask = last_vec;
                        end else begin
                            shift_mask = lldq_pkg::prefix_or(match_vec);
                        end
                        n_count = r_count - lldq_pkg::COUNT_W'(1);
                    end
                end
                default: begin
                    n_status = lldq_pkg::STATUS_DONE;
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (shift_left_all) begin
                cell_op[i] = (i == 0) ? lldq_pkg::CELL_LOAD : lldq_pkg::CELL_FROM_LEFT;
            end else if (load_vec[i]) begin
                cell_op[i] = lldq_pkg::CELL_LOAD;
            end else if (shift_mask[i]) begin
                cell_op[i] = lldq_pkg::CELL_FROM_RIGHT;
            end else begin
                cell_op[i] = lldq_pkg::CELL_HOLD;
            end
        end
    end

    always_comb begin
        unique case (r_state)
            lldq_pkg::ST_IDLE:   n_state = start ? lldq_pkg::ST_EXEC : lldq_pkg::ST_IDLE;
            lldq_pkg::ST_EXEC:   n_state = lldq_pkg::ST_REPORT;
            lldq_pkg::ST_REPORT: n_state = start ? lldq_pkg::ST_EXEC : lldq_pkg::ST_IDLE;
            default:             n_state = lldq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lldq_pkg::ST_IDLE;
            r_count  <= '0;
            r_status <= lldq_pkg::STATUS_DONE;
        end else begin
            r_state <= n_state;
            if (r_state == lldq_pkg::ST_EXEC) begin
                r_count  <= n_count;
                r_status <= n_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_command <= i_cmd.command;
            r_value   <= i_cmd.value;
        end
    end

    always_comb begin
        back_value = '0;
        for (int i = 0; i < N; i++) begin
            back_value = back_value | (last_vec[i] ? cell_data[i].value : '0);
        end
    end

    always_comb begin
        busy   = (r_state == lldq_pkg::ST_EXEC);
        o_done = (r_state == lldq_pkg::ST_REPORT);
    end

    always_comb begin
        o_result.status      = r_status;
        o_result.count       = r_count;
        o_result.is_empty    = is_empty;
        o_result.front_value = valid_vec[0] ? cell_data[0].value : '0;
        o_result.back_value  = back_value;
    end

endmodule
